/* hdl/rsi_pkg.sv */
// ----------------------------------------------------------------------------
// RSI package
// Widths, fixed-point constants and shared types for the relative strength
// index block.
// ----------------------------------------------------------------------------
package rsi_pkg;

  // Width of the closing price and of the window length register.
  localparam int unsigned PRICE_W = 32;
  localparam int unsigned WIN_W   = 7;
  localparam int unsigned BAR_W   = WIN_W + 1;

  // RSI result in unsigned Q7.16.
  localparam int unsigned RSI_W    = 23;
  localparam int unsigned RSI_IDX_W = $clog2(RSI_W);
  localparam logic [RSI_W-1:0] RSI_FIFTY   = 23'd3276800;
  localparam logic [RSI_W-1:0] RSI_HUNDRED = 23'd6553600;

  // Window length after reset.
  localparam logic [WIN_W-1:0] WIN_RESET = 7'd14;

  // Classification of one bar, handed from the front end to the divider.
  typedef struct packed {
    logic hist_full;   // window is filled, the RSI is valid
    logic loss_small;  // loss sum below the window length: RSI is 100
  } job_flags_t;

endpackage

/* hdl/rsi_front.sv */
// ----------------------------------------------------------------------------
// RSI front end
// Accepts closing prices, keeps the change ring and the running gain and loss
// sums, and posts one job per bar to the job queue.
// ----------------------------------------------------------------------------
module rsi_front import rsi_pkg::*; #(
  parameter int unsigned MAX_WINDOW = 64,
  parameter int unsigned SUM_W      = 38
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [WIN_W-1:0]   cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [PRICE_W-1:0] close_price_i,
  input  logic               queue_full_i,
  output logic               push_o,
  output logic [SUM_W-1:0]   push_gain_o,
  output logic [SUM_W-1:0]   push_loss_o,
  output job_flags_t         push_flags_o
);

  localparam int unsigned PTR_W     = $clog2(MAX_WINDOW);
  localparam int unsigned CNT_W     = ((PTR_W > WIN_W) ? PTR_W : WIN_W) + 1;
  localparam int unsigned MAX_CLAMP = (MAX_WINDOW > 127) ? 127 : MAX_WINDOW;
  localparam logic [WIN_W-1:0] MAX_EFF = WIN_W'(MAX_CLAMP);
  localparam int unsigned CHG_W     = PRICE_W + 1;

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_DROP = 4'b0010,
    F_ADD  = 4'b0100,
    F_PUSH = 4'b1000
  } front_state_e;

  front_state_e        state_q, state_d;
  logic [WIN_W-1:0]    window_q;
  logic [WIN_W-1:0]    win_eff;
  logic [PRICE_W-1:0]  last_close_q;
  logic [CHG_W-1:0]    change_q;
  logic [PTR_W-1:0]    ptr_q;
  logic [PTR_W-1:0]    ptr_next;
  logic [SUM_W-1:0]    gain_q;
  logic [SUM_W-1:0]    loss_q;
  logic [BAR_W-1:0]    bars_q;
  logic [BAR_W-1:0]    bars_limit;
  logic                hist_full;
  logic                accept;
  logic                mem_re;
  logic                mem_we;
  logic [CHG_W-1:0]    ring_mem [MAX_WINDOW];
  logic [CHG_W-1:0]    old_q;
  logic [CHG_W-1:0]    old_neg;
  logic [CHG_W-1:0]    new_neg;

  // Effective window: zero acts as one, values above the ring depth clamp.
  always_comb begin
    if (window_q == '0) begin
      win_eff = WIN_W'(1);
    end else if (window_q > MAX_EFF) begin
      win_eff = MAX_EFF;
    end else begin
      win_eff = window_q;
    end
  end

  assign bars_limit = BAR_W'(win_eff) + BAR_W'(1);
  assign hist_full  = (bars_q >= bars_limit);
  assign accept     = in_valid_i && (state_q == F_IDLE);
  assign in_stall_o = (state_q != F_IDLE);
  assign mem_re     = accept && (bars_q != '0);
  assign mem_we     = (state_q == F_ADD);
  assign old_neg    = -old_q;
  assign new_neg    = -change_q;

  // Ring pointer wraps at the effective window.
  always_comb begin
    if ((CNT_W'(ptr_q) + CNT_W'(1)) == CNT_W'(win_eff)) begin
      ptr_next = '0;
    end else begin
      ptr_next = ptr_q + PTR_W'(1);
    end
  end

  // Change ring: one read and one write port, registered read data.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring_mem[ptr_q] <= change_q;
    end
    if (mem_re) begin
      old_q <= ring_mem[ptr_q];
    end
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE: begin
        if (accept) begin
          state_d = (bars_q == '0) ? F_PUSH : F_DROP;
        end
      end
      F_DROP: state_d = F_ADD;
      F_ADD:  state_d = F_PUSH;
      F_PUSH: begin
        if (!queue_full_i) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  // Change of the accepted close; payload register.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      change_q <= {1'b0, close_price_i} - {1'b0, last_close_q};
    end
  end

  // History state, window register and running sums.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= F_IDLE;
      window_q     <= WIN_RESET;
      last_close_q <= '0;
      ptr_q        <= '0;
      gain_q       <= '0;
      loss_q       <= '0;
      bars_q       <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        window_q <= cfg_wdata_i;
        ptr_q    <= '0;
        gain_q   <= '0;
        loss_q   <= '0;
        bars_q   <= '0;
      end else begin
        case (state_q)
          F_IDLE: begin
            if (accept) begin
              last_close_q <= close_price_i;
              if (bars_q == '0) begin
                bars_q <= BAR_W'(1);
              end
            end
          end
          F_DROP: begin
            // Retire the oldest change once the window is full.
            if (hist_full && (old_q != '0)) begin
              if (!old_q[CHG_W-1]) begin
                gain_q <= gain_q - SUM_W'(old_q[PRICE_W-1:0]);
              end else begin
                loss_q <= loss_q - SUM_W'(old_neg[PRICE_W-1:0]);
              end
            end
          end
          F_ADD: begin
            if (change_q != '0) begin
              if (!change_q[CHG_W-1]) begin
                gain_q <= gain_q + SUM_W'(change_q[PRICE_W-1:0]);
              end else begin
                loss_q <= loss_q + SUM_W'(new_neg[PRICE_W-1:0]);
              end
            end
            ptr_q <= ptr_next;
            if (!hist_full) begin
              bars_q <= bars_q + BAR_W'(1);
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Job request towards the divider.
  assign push_o                  = (state_q == F_PUSH) && !queue_full_i;
  assign push_gain_o             = gain_q;
  assign push_loss_o             = loss_q;
  assign push_flags_o.hist_full  = hist_full;
  assign push_flags_o.loss_small = (loss_q < SUM_W'(win_eff));

endmodule

/* hdl/rsi_fifo.sv */
// ----------------------------------------------------------------------------
// RSI job queue
// Two-entry queue between the front end and the divider.
// ----------------------------------------------------------------------------
module rsi_fifo import rsi_pkg::*; #(
  parameter int unsigned WIDTH = 78
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] pop_data_o
);

  logic [WIDTH-1:0] entries_q [2];
  logic             wr_ptr_q;
  logic             rd_ptr_q;
  logic [1:0]       count_q;

  assign full_o     = (count_q == 2'd2);
  assign empty_o    = (count_q == 2'd0);
  assign pop_data_o = entries_q[rd_ptr_q];

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

/* hdl/rsi_back.sv */
// ----------------------------------------------------------------------------
// RSI back end
// Takes jobs from the queue, runs the serial scaled divider and holds the
// result in the output register.
// ----------------------------------------------------------------------------
module rsi_back import rsi_pkg::*; #(
  parameter int unsigned SUM_W = 38
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             queue_empty_i,
  output logic             pop_o,
  input  logic [SUM_W-1:0] job_gain_i,
  input  logic [SUM_W-1:0] job_loss_i,
  input  job_flags_t       job_flags_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [RSI_W-1:0] rsi_value_o,
  output logic             rsi_ready_o
);

  localparam int unsigned REM_W = SUM_W + 2;

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_DIV  = 3'b010,
    B_OUT  = 3'b100
  } back_state_e;

  back_state_e          state_q, state_d;
  logic [SUM_W-1:0]     g_q;
  logic [SUM_W-1:0]     d_q;
  logic [REM_W-1:0]     r_q;
  logic [REM_W-1:0]     r_next;
  logic [REM_W-1:0]     t_sum;
  logic [REM_W-1:0]     d_one;
  logic [REM_W-1:0]     d_two;
  logic [RSI_W-1:0]     q_q;
  logic [RSI_W-1:0]     q_next;
  logic [1:0]           digit;
  logic [RSI_IDX_W-1:0] bit_q;
  logic [RSI_W-1:0]     res_q;
  logic                 res_ready_q;
  logic                 out_valid_q;
  logic                 out_free;
  logic                 out_load;

  assign out_free = !out_valid_q || !out_stall_i;
  assign out_load = (state_q == B_OUT) && out_free;
  assign pop_o    = (state_q == B_IDLE) && !queue_empty_i;

  // One divider step: bring in the next multiplier bit, then subtract the
  // divisor up to twice. The remainder stays below the divisor.
  assign d_one = REM_W'(d_q);
  assign d_two = REM_W'({d_q, 1'b0});
  assign t_sum = {r_q[REM_W-2:0], 1'b0} + (RSI_HUNDRED[bit_q] ? REM_W'(g_q) : '0);

  always_comb begin
    if (t_sum >= d_two) begin
      r_next = t_sum - d_two;
      digit  = 2'd2;
    end else if (t_sum >= d_one) begin
      r_next = t_sum - d_one;
      digit  = 2'd1;
    end else begin
      r_next = t_sum;
      digit  = 2'd0;
    end
  end

  assign q_next = {q_q[RSI_W-2:0], 1'b0} + RSI_W'(digit);

  // Sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE: begin
        if (pop_o) begin
          if (job_flags_i.hist_full && !job_flags_i.loss_small) begin
            state_d = B_DIV;
          end else begin
            state_d = B_OUT;
          end
        end
      end
      B_DIV: begin
        if (bit_q == '0) begin
          state_d = B_OUT;
        end
      end
      B_OUT: begin
        if (out_free) begin
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  // Divider datapath and pending result.
  always_ff @(posedge clk_i) begin
    case (state_q)
      B_IDLE: begin
        if (pop_o) begin
          g_q   <= job_gain_i;
          d_q   <= job_gain_i + job_loss_i;
          r_q   <= '0;
          q_q   <= '0;
          bit_q <= RSI_IDX_W'(RSI_W - 1);
          if (!job_flags_i.hist_full) begin
            res_q       <= RSI_FIFTY;
            res_ready_q <= 1'b0;
          end else begin
            res_q       <= RSI_HUNDRED;
            res_ready_q <= 1'b1;
          end
        end
      end
      B_DIV: begin
        r_q   <= r_next;
        q_q   <= q_next;
        bit_q <= bit_q - RSI_IDX_W'(1);
        if (bit_q == '0) begin
          res_q <= q_next;
        end
      end
      default: begin
      end
    endcase
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      rsi_value_o <= res_q;
      rsi_ready_o <= res_ready_q;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* hdl/relative_strength_index.sv */
// Flow: after taking a price the front end steps through its drop, add and push
// states (a first bar only push) before it takes another. Warm-up and
// full-scale bars skip the divider; a dividing bar occupies the 23-step serial
// divider, and no new job leaves the queue until its result is registered.
// Reset: asynchronous, active low; window length 14, history cleared. The
// change ring is not cleared; an entry is used only after it was written.
// ----------------------------------------------------------------------------
// Relative strength index
// Sliding-window RSI over close-to-close changes, result in unsigned Q7.16.
// ----------------------------------------------------------------------------
module relative_strength_index import rsi_pkg::*; #(
  parameter int unsigned MAX_WINDOW = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [WIN_W-1:0]   cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [PRICE_W-1:0] close_price_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [RSI_W-1:0]   rsi_value_o,
  output logic               rsi_ready_o
);

  localparam int unsigned SUM_W = PRICE_W + $clog2(MAX_WINDOW);
  localparam int unsigned JOB_W = 2 * SUM_W + $bits(job_flags_t);

  logic             push;
  logic             pop;
  logic             queue_full;
  logic             queue_empty;
  logic [SUM_W-1:0] push_gain;
  logic [SUM_W-1:0] push_loss;
  job_flags_t       push_flags;
  logic [JOB_W-1:0] pop_data;
  logic [SUM_W-1:0] job_gain;
  logic [SUM_W-1:0] job_loss;
  job_flags_t       job_flags;

  // Front end: price intake, change ring and running sums.
  rsi_front #(
    .MAX_WINDOW (MAX_WINDOW),
    .SUM_W      (SUM_W)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .close_price_i (close_price_i),
    .queue_full_i  (queue_full),
    .push_o        (push),
    .push_gain_o   (push_gain),
    .push_loss_o   (push_loss),
    .push_flags_o  (push_flags)
  );

  // Job queue between the two halves.
  rsi_fifo #(
    .WIDTH (JOB_W)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i ({push_flags, push_gain, push_loss}),
    .full_o      (queue_full),
    .pop_i       (pop),
    .empty_o     (queue_empty),
    .pop_data_o  (pop_data)
  );

  assign {job_flags, job_gain, job_loss} = pop_data;

  // Back end: serial divider and output register.
  rsi_back #(
    .SUM_W (SUM_W)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .queue_empty_i (queue_empty),
    .pop_o         (pop),
    .job_gain_i    (job_gain),
    .job_loss_i    (job_loss),
    .job_flags_i   (job_flags),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .rsi_value_o   (rsi_value_o),
    .rsi_ready_o   (rsi_ready_o)
  );

  // A result that is not yet valid always carries the neutral value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !rsi_ready_o) |-> (rsi_value_o == RSI_FIFTY))
    else $error("warm-up result is not neutral");

  // The RSI never exceeds full scale.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (rsi_value_o <= RSI_HUNDRED))
    else $error("RSI above full scale");

  // After taking a price the front end is busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("front end took two prices back to back");

endmodule

/* tb/relative_strength_index_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Relative strength index testbench
// Feeds closing prices to the RSI block with random gaps on the price side and
// random stalls on the result side. A behavioral window model predicts each RSI
// value that a plan row does not give; each result is compared field by field.
// ----------------------------------------------------------------------------
module relative_strength_index_test import rsi_pkg::*;;

  localparam int unsigned MAX_WIN      = 64;
  localparam int unsigned SUM_W        = 38;
  localparam int unsigned REPORT_LIMIT = 10;
  // The result side holds off once, for a long stretch, after this many results.
  localparam int unsigned HOLD_AT      = 300;
  localparam int unsigned HOLD_CYCLES  = 500;
  // This covers the latency of the last result with margin.
  localparam int unsigned SETTLE_CYCLES = 64;

  typedef struct packed {
    logic [RSI_W-1:0] rsi;
    logic             ready;
  } rsi_result_t;

  typedef enum logic {ROW_BAR, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    logic [PRICE_W-1:0] value;
    logic               typed;
    rsi_result_t        want;
  } step_row_t;

  typedef enum logic [1:0] {WALK_RISE, WALK_CHOP, WALK_SWING, WALK_WILD} walk_mode_e;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_we;
  logic [WIN_W-1:0]   cfg_wdata;
  logic               in_valid;
  logic               in_stall;
  logic [PRICE_W-1:0] close_price;
  logic               out_valid;
  logic               out_stall;
  logic [RSI_W-1:0]   rsi_value;
  logic               rsi_ready;

  // Model of the window, its sums and the history counters.
  logic [WIN_W-1:0]          win_reg;
  logic [PRICE_W-1:0]        prev_close;
  logic signed [PRICE_W:0]   change_mem [MAX_WIN];
  int unsigned               ring_at;
  int unsigned               bars_count;
  logic [SUM_W-1:0]          gain_sum;
  logic [SUM_W-1:0]          loss_sum;

  rsi_result_t rsi_expect_q [$];
  int unsigned error_count  = 0;
  int unsigned bars_sent    = 0;
  int unsigned results_seen = 0;
  int unsigned stall_left   = 0;
  bit          send_eager   = 1'b0;
  bit          take_eager   = 1'b0;

  relative_strength_index DUT (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .close_price_i (close_price),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .rsi_value_o   (rsi_value),
    .rsi_ready_o   (rsi_ready)
  );

  always #1 clk = ~clk;

  // Cycles to wait before the next request; no wait while a side runs eagerly.
  function automatic int unsigned pause_len(input bit eager);
    return eager ? 0 : $urandom_range(13, 0);
  endfunction

  function automatic step_row_t step_row(input row_kind_e kind,
                                         input logic [PRICE_W-1:0] value,
                                         input logic typed,
                                         input logic [RSI_W-1:0] rsi,
                                         input logic ready);
    step_row_t r;
    r.kind      = kind;
    r.value     = value;
    r.typed     = typed;
    r.want.rsi  = rsi;
    r.want.ready = ready;
    return r;
  endfunction

  // Advances the window model by one bar and returns the RSI it should give.
  function automatic rsi_result_t predict_rsi(input logic [PRICE_W-1:0] price);
    int unsigned             w;
    int unsigned             slot;
    logic signed [PRICE_W:0] delta;
    logic signed [PRICE_W:0] dropped;
    logic [63:0]             scaled;
    rsi_result_t             r;
    if (win_reg == 0) w = 1;
    else if (win_reg > MAX_WIN) w = MAX_WIN;
    else w = 32'(win_reg);
    r.rsi   = RSI_FIFTY;
    r.ready = 1'b0;
    if (bars_count == 0) begin
      // The first bar after a restart only loads the previous close.
      prev_close = price;
      bars_count = 1;
    end else begin
      delta = $signed({1'b0, price}) - $signed({1'b0, prev_close});
      slot = ring_at % w;
      prev_close = price;
      // Once the window is full, the oldest change leaves the sums.
      if (bars_count >= w + 1) begin
        dropped = change_mem[slot];
        if (dropped > 0) gain_sum -= SUM_W'(dropped);
        else if (dropped < 0) loss_sum -= SUM_W'(-dropped);
      end
      change_mem[slot] = delta;
      if (delta > 0) gain_sum += SUM_W'(delta);
      else if (delta < 0) loss_sum += SUM_W'(-delta);
      ring_at = (slot + 1) % w;
      if (bars_count < w + 1) bars_count++;
      if (bars_count >= w + 1) begin
        r.ready = 1'b1;
        // An average loss under one tick reads as full strength.
        if (loss_sum < SUM_W'(w)) begin
          r.rsi = RSI_HUNDRED;
        end else begin
          scaled = 64'(gain_sum) * 64'(RSI_HUNDRED);
          r.rsi  = RSI_W'(scaled / (64'(gain_sum) + 64'(loss_sum)));
        end
      end
    end
    return r;
  endfunction

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= REPORT_LIMIT) $display("%s", msg);
  endtask

  // Called at a falling edge; returns at a falling edge once nothing is owed.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (rsi_expect_q.size() != 0) @(negedge clk);
  endtask

  // Offers one price, waits for it to be taken, and queues its expected RSI.
  task automatic offer_bar(input logic [PRICE_W-1:0] price, input logic typed,
                           input rsi_result_t want);
    int unsigned gap;
    rsi_result_t model;
    gap = pause_len(send_eager);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    close_price <= price;
    do @(posedge clk); while (in_stall);
    model = predict_rsi(price);
    rsi_expect_q.insert(rsi_expect_q.size(), typed ? want : model);
    bars_sent++;
    if (bars_sent % 40 == 0) send_eager = ($urandom_range(2, 0) == 0);
    @(negedge clk);
  endtask

  // The window register is written only with no request in flight.
  task automatic write_window(input logic [WIN_W-1:0] value);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we     <= 1'b0;
    win_reg    = value;
    ring_at    = 0;
    gain_sum   = '0;
    loss_sum   = '0;
    bars_count = 0;
  endtask

  // Result side: check every accepted result and pick the next stall.
  initial begin : result_check
    rsi_result_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        results_seen++;
        if (rsi_expect_q.size() == 0) begin
          flag_error($sformatf("result %0d with no request outstanding: rsi %0d ready %0b",
                               results_seen, rsi_value, rsi_ready));
        end else begin
          want = rsi_expect_q.pop_front();
          if (rsi_value !== want.rsi || rsi_ready !== want.ready)
            flag_error($sformatf("result %0d: expected rsi %0d ready %0b, got rsi %0d ready %0b",
                                 results_seen, want.rsi, want.ready, rsi_value, rsi_ready));
        end
        if (results_seen % 50 == 0) take_eager = ($urandom_range(2, 0) == 0);
        stall_left = (results_seen == HOLD_AT) ? HOLD_CYCLES : pause_len(take_eager);
      end
    end
  end

  // Result side stall, counted down at the falling edge.
  initial begin : result_stall
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Stops a run that hangs, well past the length of a correct run.
  initial begin : watchdog
    #2_000_000;
    $display("relative_strength_index_test: done, errors");
    $finish;
  end

  initial begin : stimulus
    step_row_t          plan [$];
    logic [WIN_W-1:0]   phase_win [10];
    int unsigned        phase_len;
    int unsigned        n;
    walk_mode_e         walk;
    logic [PRICE_W-1:0] walk_close;
    longint             cand;

    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_wdata   = '0;
    in_valid    = 1'b0;
    close_price = '0;
    win_reg     = WIN_RESET;
    prev_close  = '0;
    ring_at     = 0;
    bars_count  = 0;
    gain_sum    = '0;
    loss_sum    = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part: warm-up, no losses, only losses, zero change, price
    // extremes, window lengths out of range and the loss threshold edge.
    plan = '{
      step_row(ROW_CFG, 32'd2,          1'b0, '0,          1'b0),
      step_row(ROW_BAR, 32'd100,        1'b1, RSI_FIFTY,   1'b0),
      step_row(ROW_BAR, 32'd100,        1'b1, RSI_FIFTY,   1'b0),
      step_row(ROW_BAR, 32'd105,        1'b1, RSI_HUNDRED, 1'b1),
      step_row(ROW_BAR, 32'd95,         1'b0, '0,          1'b0),
      step_row(ROW_BAR, 32'd0,          1'b1, '0,          1'b1),
      step_row(ROW_BAR, 32'hFFFF_FFFF,  1'b0, '0,          1'b0),
      step_row(ROW_BAR, 32'd0,          1'b0, '0,          1'b0),
      step_row(ROW_CFG, 32'd0,          1'b0, '0,          1'b0),
      step_row(ROW_BAR, 32'd7,          1'b1, RSI_FIFTY,   1'b0),
      step_row(ROW_BAR, 32'd6,          1'b1, '0,          1'b1),
      step_row(ROW_BAR, 32'd6,          1'b1, RSI_HUNDRED, 1'b1),
      step_row(ROW_BAR, 32'd9,          1'b1, RSI_HUNDRED, 1'b1),
      step_row(ROW_CFG, 32'd127,        1'b0, '0,          1'b0),
      step_row(ROW_BAR, 32'hFFFF_FFFF,  1'b1, RSI_FIFTY,   1'b0),
      step_row(ROW_BAR, 32'd0,          1'b1, RSI_FIFTY,   1'b0),
      step_row(ROW_CFG, 32'd3,          1'b0, '0,          1'b0),
      step_row(ROW_BAR, 32'd10,         1'b1, RSI_FIFTY,   1'b0),
      step_row(ROW_BAR, 32'd12,         1'b1, RSI_FIFTY,   1'b0),
      step_row(ROW_BAR, 32'd11,         1'b1, RSI_FIFTY,   1'b0),
      step_row(ROW_BAR, 32'd12,         1'b1, RSI_HUNDRED, 1'b1),
      step_row(ROW_BAR, 32'd10,         1'b0, '0,          1'b0),
      step_row(ROW_BAR, 32'd13,         1'b0, '0,          1'b0),
      step_row(ROW_CFG, 32'd64,         1'b0, '0,          1'b0),
      step_row(ROW_BAR, 32'h8000_0000,  1'b1, RSI_FIFTY,   1'b0),
      step_row(ROW_BAR, 32'h7FFF_FFFF,  1'b1, RSI_FIFTY,   1'b0)
    };
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) write_window(plan[i].value[WIN_W-1:0]);
      else offer_bar(plan[i].value, plan[i].typed, plan[i].want);
    end

    // Random part: one phase per window setting. Each phase drains first, so
    // the price side also pauses until every owed result has come back.
    phase_win = '{7'd14, 7'd1, 7'd64, 7'd0, 7'd127, 7'd3, 7'd65, 7'd2, 7'd5, 7'd9};
    phase_win[8] = WIN_W'($urandom_range(20, 1));
    phase_win[9] = WIN_W'($urandom_range(127, 0));
    foreach (phase_win[p]) begin
      write_window(phase_win[p]);
      phase_len  = (phase_win[p] > 20) ? 180 : 100;
      walk_close = $urandom();
      walk       = WALK_CHOP;
      for (n = 0; n < phase_len; n++) begin
        // Prices follow a walk whose character changes every few dozen bars.
        if (n % 24 == 0) begin
          case ($urandom_range(9, 0))
            0, 1, 2, 3: walk = WALK_RISE;
            4, 5, 6:    walk = WALK_CHOP;
            7, 8:       walk = WALK_SWING;
            default:    walk = WALK_WILD;
          endcase
        end
        case (walk)
          WALK_RISE:  cand = longint'(walk_close) + $urandom_range(40, 0)
                             - (($urandom_range(7, 0) == 0) ? 1 : 0);
          WALK_CHOP:  cand = longint'(walk_close) + $urandom_range(16, 0) - 8;
          WALK_SWING: cand = longint'(walk_close) + $urandom_range(131071, 0) - 65536;
          default: begin
            case ($urandom_range(3, 0))
              0:       cand = 0;
              1:       cand = 64'sd4294967295;
              default: cand = longint'($urandom());
            endcase
          end
        endcase
        if (cand < 0) cand = 0;
        else if (cand > 64'sd4294967295) cand = 64'sd4294967295;
        walk_close = cand[PRICE_W-1:0];
        offer_bar(walk_close, 1'b0, '0);
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (error_count == 0) begin
      $display("relative_strength_index_test: done, clean");
    end else begin
      $display("relative_strength_index_test: done, errors");
    end
    $finish;
  end

endmodule
